// File: rtl/dch_pkg.sv
// Shared types and constants of the distinct color histogram.
package dch_pkg;

    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic KIND_COLOR   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int OUT_COUNT_WIDTH = 24;
    localparam int DISTINCT_WIDTH  = 6;

    typedef struct packed {
        logic        op;
        logic [31:0] pixel_argb;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PICK,
        ST_EMIT,
        ST_SUMMARY,
        ST_CLEAR
    } back_state_t;

    function automatic logic [31:0] rgba_key(input logic [31:0] argb);
        rgba_key = {argb[23:0], argb[31:24]};
    endfunction

endpackage

// File: rtl/dch_front.sv
// Front part: input queue of pixel and finish items ahead of the histogram engine.
module dch_front #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dch_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          cmd_valid,
    output dch_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dch_pkg::cmd_t    mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count out of range");
    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_pop |=> cnt_reg == $past(cnt_reg))
        else $error("queue grew while full");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("pop did not shrink queue");
endmodule

// File: rtl/dch_back.sv
// Back part: color table with parallel match, selection readout and result queue.
module dch_back #(
    parameter int TABLE_SIZE  = 32,
    parameter int COUNT_WIDTH = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  dch_pkg::cmd_t cmd,
    output logic          cmd_take,
    output logic          empty,
    input  logic          pop,
    output logic          kind,
    output logic [31:0]   color_argb,
    output logic [23:0]   pixel_count,
    output logic [23:0]   transparent_count,
    output logic [5:0]    distinct_count,
    output logic          table_overflow,
    output logic          last
);
    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int NW = $clog2(TABLE_SIZE + 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [31:0]            key_reg [TABLE_SIZE];
    logic [COUNT_WIDTH-1:0] cnt_reg [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]  done_reg, done_next;
    logic [NW-1:0]          used_reg, used_next;
    logic [COUNT_WIDTH-1:0] trans_reg, trans_next;
    logic                   ovf_reg, ovf_next;
    dch_pkg::back_state_t   state_reg, state_next;
    logic [IW-1:0]          scan_reg, scan_next, best_reg, best_next;
    logic                   have_reg, have_next;
    logic [NW-1:0]          left_reg, left_next;

    logic                   out_valid_reg;
    logic                   out_kind_reg, out_last_reg, out_ovf_reg;
    logic [31:0]            out_color_reg;
    logic [23:0]            out_pcnt_reg, out_tcnt_reg;
    logic [5:0]             out_dist_reg;

    logic [TABLE_SIZE-1:0]  hit;
    logic                   any_hit;
    logic [IW-1:0]          hit_idx;
    logic                   is_pixel, opaque;
    logic                   better;
    logic                   out_free;
    logic                   emit_color, emit_summary;

    assign out_free = !out_valid_reg || pop;
    assign is_pixel = cmd_valid && (state_reg == dch_pkg::ST_LOAD)
                      && (cmd.op == dch_pkg::OP_PIXEL);
    assign opaque   = (cmd.pixel_argb[31:24] != 8'd0);

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            hit[i] = (NW'(i) < used_reg) && (key_reg[i] == cmd.pixel_argb);
            if (hit[i])
            begin
                hit_idx = IW'(i);
            end
        end
        any_hit = |hit;
    end

    always_comb
    begin
        better = !have_reg
            || (cnt_reg[scan_reg] > cnt_reg[best_reg])
            || ((cnt_reg[scan_reg] == cnt_reg[best_reg])
                && (dch_pkg::rgba_key(key_reg[scan_reg])
                    < dch_pkg::rgba_key(key_reg[best_reg])));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dch_pkg::ST_LOAD:
            begin
                if (cmd_valid && cmd.op == dch_pkg::OP_FINISH)
                begin
                    state_next = (used_reg == '0) ? dch_pkg::ST_SUMMARY : dch_pkg::ST_PICK;
                end
            end
            dch_pkg::ST_PICK:
            begin
                if (NW'(scan_reg) == used_reg - 1'b1)
                begin
                    state_next = dch_pkg::ST_EMIT;
                end
            end
            dch_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (left_reg == NW'(1)) ? dch_pkg::ST_SUMMARY
                                                      : dch_pkg::ST_PICK;
                end
            end
            dch_pkg::ST_SUMMARY:
            begin
                if (out_free)
                begin
                    state_next = dch_pkg::ST_CLEAR;
                end
            end
            dch_pkg::ST_CLEAR:
            begin
                state_next = dch_pkg::ST_LOAD;
            end
            default:
            begin
                state_next = dch_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd_take     = 1'b0;
        emit_color   = 1'b0;
        emit_summary = 1'b0;
        unique case (state_reg)
            dch_pkg::ST_LOAD:    cmd_take     = cmd_valid;
            dch_pkg::ST_EMIT:    emit_color   = out_free;
            dch_pkg::ST_SUMMARY: emit_summary = out_free;
            default:             cmd_take     = 1'b0;
        endcase
    end

    always_comb
    begin
        used_next  = used_reg;
        trans_next = trans_reg;
        ovf_next   = ovf_reg;
        done_next  = done_reg;
        scan_next  = scan_reg;
        best_next  = best_reg;
        have_next  = have_reg;
        left_next  = left_reg;
        if (is_pixel)
        begin
            if (!opaque)
            begin
                trans_next = (trans_reg == CMAX) ? trans_reg : trans_reg + 1'b1;
            end
            else if (!any_hit)
            begin
                if (used_reg < NW'(TABLE_SIZE))
                begin
                    used_next = used_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
        if (state_reg == dch_pkg::ST_LOAD && cmd_valid && cmd.op == dch_pkg::OP_FINISH)
        begin
            done_next = '0;
            scan_next = '0;
            have_next = 1'b0;
            left_next = used_reg;
        end
        if (state_reg == dch_pkg::ST_PICK)
        begin
            if (!done_reg[scan_reg] && better)
            begin
                best_next = scan_reg;
                have_next = 1'b1;
            end
            scan_next = scan_reg + 1'b1;
        end
        if (emit_color)
        begin
            done_next[best_reg] = 1'b1;
            left_next = left_reg - 1'b1;
            scan_next = '0;
            have_next = 1'b0;
        end
        if (state_reg == dch_pkg::ST_CLEAR)
        begin
            used_next  = '0;
            trans_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dch_pkg::ST_LOAD;
            used_reg      <= '0;
            trans_reg     <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= '0;
            scan_reg      <= '0;
            best_reg      <= '0;
            have_reg      <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            trans_reg <= trans_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
            scan_reg  <= scan_next;
            best_reg  <= best_next;
            have_reg  <= have_next;
            left_reg  <= left_next;
            if (emit_color || emit_summary)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_pixel && opaque)
        begin
            if (any_hit)
            begin
                if (cnt_reg[hit_idx] != CMAX)
                begin
                    cnt_reg[hit_idx] <= cnt_reg[hit_idx] + 1'b1;
                end
            end
            else if (used_reg < NW'(TABLE_SIZE))
            begin
                key_reg[used_reg[IW-1:0]] <= cmd.pixel_argb;
                cnt_reg[used_reg[IW-1:0]] <= COUNT_WIDTH'(1);
            end
        end
        if (emit_color)
        begin
            out_kind_reg  <= dch_pkg::KIND_COLOR;
            out_color_reg <= key_reg[best_reg];
            out_pcnt_reg  <= 24'(cnt_reg[best_reg]);
            out_tcnt_reg  <= '0;
            out_dist_reg  <= '0;
            out_ovf_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (emit_summary)
        begin
            out_kind_reg  <= dch_pkg::KIND_SUMMARY;
            out_color_reg <= '0;
            out_pcnt_reg  <= '0;
            out_tcnt_reg  <= 24'(trans_reg);
            out_dist_reg  <= 6'(used_reg);
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign empty             = !out_valid_reg;
    assign kind              = out_kind_reg;
    assign color_argb        = out_color_reg;
    assign pixel_count       = out_pcnt_reg;
    assign transparent_count = out_tcnt_reg;
    assign distinct_count    = out_dist_reg;
    assign table_overflow    = out_ovf_reg;
    assign last              = out_last_reg;

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NW'(TABLE_SIZE))
        else $error("table fill above size");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != dch_pkg::ST_LOAD |-> !cmd_take)
        else $error("item taken during readout");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dch_pkg::ST_CLEAR |=> used_reg == '0 && !ovf_reg)
        else $error("store not cleared");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_color || emit_summary) |-> (!out_valid_reg || pop))
        else $error("result overwritten");
endmodule

// File: rtl/distinct_color_histogram_sort.sv
// Top level of the distinct color histogram with sorted readout.
//  channel  | handshake   | fields
//  input    | push, full  | op, pixel_argb
//  result   | empty, pop  | kind, color_argb, pixel_count, transparent_count,
//           |             | distinct_count, table_overflow, last
// Pixel items are taken by the engine only in its load state; the key match over the table is parallel.
// A finish item starts the readout: a selection scan walks the table once for each emitted
// entry, and then the summary and clear states follow.
// Reset empties both queues and the table; the result register lets the engine run one
// entry ahead of pop, and the input queue keeps taking items, until full, while readout stalls.
module distinct_color_histogram_sort #(
    parameter int TABLE_SIZE  = 32,
    parameter int COUNT_WIDTH = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [31:0] pixel_argb,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [31:0] color_argb,
    output logic [23:0] pixel_count,
    output logic [23:0] transparent_count,
    output logic [5:0]  distinct_count,
    output logic        table_overflow,
    output logic        last
);
    dch_pkg::cmd_t push_cmd, cmd;
    logic          cmd_valid, cmd_take;

    assign push_cmd.op         = op;
    assign push_cmd.pixel_argb = pixel_argb;

    dch_front #(.DEPTH(4)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .full(full),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    dch_back #(.TABLE_SIZE(TABLE_SIZE), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .empty(empty), .pop(pop), .kind(kind),
        .color_argb(color_argb), .pixel_count(pixel_count),
        .transparent_count(transparent_count), .distinct_count(distinct_count),
        .table_overflow(table_overflow), .last(last)
    );
endmodule

// File: tb/sv/tb_top.sv
// Testbench for the distinct color histogram: directed table, random frames, scoreboard.
`timescale 1ns / 100ps

module tb_top;

    localparam int TABLE_DEPTH = 32;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 2000;
    localparam int RANDOM_ITEMS = 460;

    typedef struct {
        logic        kind;
        logic [31:0] color;
        logic [23:0] count;
        logic [23:0] transparent;
        logic [5:0]  distinct;
        logic        overflow;
        logic        last;
    } hist_entry_t;

    typedef struct {
        logic        op;
        logic [31:0] argb;
        bit          typed;
        hist_entry_t entry;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        op = dch_pkg::OP_PIXEL;
    logic [31:0] pixel_argb = 32'h0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic        kind;
    logic [31:0] color_argb;
    logic [23:0] pixel_count;
    logic [23:0] transparent_count;
    logic [5:0]  distinct_count;
    logic        table_overflow;
    logic        last;

    distinct_color_histogram_sort dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .pixel_argb(pixel_argb), .empty(empty), .pop(pop), .kind(kind),
        .color_argb(color_argb), .pixel_count(pixel_count),
        .transparent_count(transparent_count), .distinct_count(distinct_count),
        .table_overflow(table_overflow), .last(last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Own copy of the color table.
    logic [31:0] model_keys [TABLE_DEPTH];
    logic [23:0] model_counts [TABLE_DEPTH];
    int          model_used;
    logic [23:0] model_transparent;
    logic        model_overflow;

    hist_entry_t expected_entries [$];
    int          mismatches = 0;
    bit          quiet_phase = 0;
    bit          hold_request = 0;
    int          stall_cycles = 0;

    localparam hist_entry_t SUMMARY_EMPTY =
        '{dch_pkg::KIND_SUMMARY, 32'h0, 24'h0, 24'h0, 6'd0, 1'b0, 1'b1};
    localparam hist_entry_t SUMMARY_TWO_CLEAR =
        '{dch_pkg::KIND_SUMMARY, 32'h0, 24'h0, 24'd2, 6'd0, 1'b0, 1'b1};
    localparam hist_entry_t NO_ENTRY = '{1'b0, 32'h0, 24'h0, 24'h0, 6'd0, 1'b0, 1'b0};

    dir_row_t directed_rows [] = '{
        '{dch_pkg::OP_FINISH, 32'h00000000, 1, SUMMARY_EMPTY},
        '{dch_pkg::OP_PIXEL,  32'h00000000, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'h00FFFFFF, 0, NO_ENTRY},
        '{dch_pkg::OP_FINISH, 32'hFFFFFFFF, 1, SUMMARY_TWO_CLEAR},
        '{dch_pkg::OP_PIXEL,  32'hFFFFFFFF, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'h01000000, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'hFFFFFFFF, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'h80102030, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'h10102030, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'h7F00FF00, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'h7F00FF00, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'h00ABCDEF, 0, NO_ENTRY},
        '{dch_pkg::OP_FINISH, 32'h5A5A5A5A, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'hFFFFFF00, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'h00000001, 0, NO_ENTRY},
        '{dch_pkg::OP_PIXEL,  32'h000000FF, 0, NO_ENTRY},
        '{dch_pkg::OP_FINISH, 32'hA5A5A5A5, 0, NO_ENTRY},
        '{dch_pkg::OP_FINISH, 32'hDEADBEEF, 1, SUMMARY_EMPTY}
    };

    function automatic bit sorts_ahead(logic [23:0] ca, logic [31:0] ka,
                                       logic [23:0] cb, logic [31:0] kb);
        if (ca != cb)
            return ca > cb;
        return {ka[23:0], ka[31:24]} < {kb[23:0], kb[31:24]};
    endfunction

    task automatic update_histogram(input logic cmd, input logic [31:0] argb, input bit keep);
        int          order [TABLE_DEPTH];
        int          j;
        int          cur;
        bit          found;
        hist_entry_t e;
        if (cmd == dch_pkg::OP_PIXEL)
        begin
            if (argb[31:24] == 8'h00)
            begin
                if (model_transparent != 24'hFFFFFF)
                    model_transparent++;
                return;
            end
            found = 0;
            for (int i = 0; i < model_used; i++)
                if (!found && model_keys[i] == argb)
                begin
                    if (model_counts[i] != 24'hFFFFFF)
                        model_counts[i]++;
                    found = 1;
                end
            if (!found)
            begin
                if (model_used < TABLE_DEPTH)
                begin
                    model_keys[model_used] = argb;
                    model_counts[model_used] = 24'd1;
                    model_used++;
                end
                else
                    model_overflow = 1'b1;
            end
            return;
        end
        for (int i = 0; i < model_used; i++)
        begin
            cur = i;
            j = i;
            while (j > 0 && sorts_ahead(model_counts[cur], model_keys[cur],
                                        model_counts[order[j-1]], model_keys[order[j-1]]))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        if (keep)
        begin
            for (int i = 0; i < model_used; i++)
            begin
                e = NO_ENTRY;
                e.kind = dch_pkg::KIND_COLOR;
                e.color = model_keys[order[i]];
                e.count = model_counts[order[i]];
                expected_entries.insert(expected_entries.size(), e);
            end
            e = '{dch_pkg::KIND_SUMMARY, 32'h0, 24'h0, model_transparent, model_used[5:0],
                  model_overflow, 1'b1};
            expected_entries.insert(expected_entries.size(), e);
        end
        model_used = 0;
        model_transparent = 24'h0;
        model_overflow = 1'b0;
    endtask

    task automatic offer_item(input logic cmd, input logic [31:0] argb,
                              input bit keep, input hist_entry_t typed_entry);
        if (!quiet_phase && $urandom_range(0, 9) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push <= 1'b1;
        op <= cmd;
        pixel_argb <= argb;
        do
            @(posedge clk);
        while (full);
        update_histogram(cmd, argb, keep);
        if (!keep)
            expected_entries.insert(expected_entries.size(), typed_entry);
    endtask

    // Result side: scoreboard plus random and long stalls.
    initial
    begin
        hist_entry_t want;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_entries.size() == 0)
                begin
                    $error("result item with nothing expected: kind %0d color %h", kind,
                           color_argb);
                    mismatches++;
                end
                else
                begin
                    want = expected_entries.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        mismatches++;
                    end
                    if (color_argb !== want.color)
                    begin
                        $error("color_argb: expected %h, got %h", want.color, color_argb);
                        mismatches++;
                    end
                    if (pixel_count !== want.count)
                    begin
                        $error("pixel_count: expected %0d, got %0d", want.count, pixel_count);
                        mismatches++;
                    end
                    if (transparent_count !== want.transparent)
                    begin
                        $error("transparent_count: expected %0d, got %0d", want.transparent,
                               transparent_count);
                        mismatches++;
                    end
                    if (distinct_count !== want.distinct)
                    begin
                        $error("distinct_count: expected %0d, got %0d", want.distinct,
                               distinct_count);
                        mismatches++;
                    end
                    if (table_overflow !== want.overflow)
                    begin
                        $error("table_overflow: expected %0d, got %0d", want.overflow,
                               table_overflow);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        mismatches++;
                    end
                end
            end
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 0;
                pop <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                pop <= 1'b1;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (rst_n)
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] palette [48];
        logic [31:0] argb;
        int          palette_size;
        int          frame_len;
        int          frame_no;
        int          random_sent;
        int          pick;
        bit          big;
        model_used = 0;
        model_transparent = 24'h0;
        model_overflow = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].op, directed_rows[i].argb, !directed_rows[i].typed,
                       directed_rows[i].entry);

        random_sent = 0;
        frame_no = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            big = (frame_no == 1) || ($urandom_range(0, 9) == 0);
            palette_size = big ? 40 : $urandom_range(1, 8);
            frame_len = big ? 80 : $urandom_range(1, 24);
            for (int i = 0; i < palette_size; i++)
            begin
                if (i > 0 && $urandom_range(0, 3) == 0)
                    palette[i] = {8'($urandom_range(1, 255)), palette[i-1][23:0]};
                else
                    palette[i] = $urandom;
            end
            if (frame_no == 5)
            begin
                push <= 1'b0;
                while (expected_entries.size() != 0)
                    @(posedge clk);
            end
            if (random_sent > 380)
                quiet_phase = 1;
            for (int j = 0; j < frame_len; j++)
            begin
                pick = $urandom_range(0, 19);
                if (big && j < palette_size)
                    argb = palette[j];
                else if (pick < 2)
                    argb = {8'h00, 24'($urandom)};
                else if (pick == 2)
                    argb = $urandom;
                else
                    argb = palette[$urandom_range(0, palette_size - 1)];
                offer_item(dch_pkg::OP_PIXEL, argb, 1, NO_ENTRY);
            end
            if (frame_no == 2)
                hold_request = 1;
            offer_item(dch_pkg::OP_FINISH, $urandom, 1, NO_ENTRY);
            random_sent += frame_len + 1;
            frame_no++;
        end
        push <= 1'b0;

        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_entries.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
